// ----- hdl/pmfc_pkg.sv -----
// Package for the pixel mask format converter.
// Holds the pixel width constants, channel configuration types and mask helper functions.
// No dependencies.
`default_nettype none

package pmfc_pkg;

    // Pixel word width and the mask of bits that carry pixel data.
    localparam int PIXEL_BITS = 32;
    localparam int WORD_BITS  = 32;
    localparam logic [WORD_BITS-1:0] ALL_ONES  = {WORD_BITS{1'b1}};
    localparam logic [WORD_BITS-1:0] PIX_MASK  = ALL_ONES >> (WORD_BITS - PIXEL_BITS);

    // Channel count and the position of each channel in the register file.
    localparam int NUM_CHAN  = 4;
    localparam int NUM_REGS  = 2 * NUM_CHAN;
    localparam int IDX_BITS  = 8;
    localparam int POS_BITS  = 5;
    localparam int WID_BITS  = 6;

    typedef enum logic [1:0] {
        CHAN_RED   = 2'd0,
        CHAN_GREEN = 2'd1,
        CHAN_BLUE  = 2'd2,
        CHAN_ALPHA = 2'd3
    } chan_t;

    // Register indexes on the configuration port.
    typedef enum logic [IDX_BITS-1:0] {
        REG_SRC_RED   = 8'd0,
        REG_SRC_GREEN = 8'd1,
        REG_SRC_BLUE  = 8'd2,
        REG_SRC_ALPHA = 8'd3,
        REG_DST_RED   = 8'd4,
        REG_DST_GREEN = 8'd5,
        REG_DST_BLUE  = 8'd6,
        REG_DST_ALPHA = 8'd7
    } reg_idx_t;

    // Reset masks: 8 bits per channel, ARGB order.
    localparam logic [WORD_BITS-1:0] RST_RED   = 32'h00FF_0000;
    localparam logic [WORD_BITS-1:0] RST_GREEN = 32'h0000_FF00;
    localparam logic [WORD_BITS-1:0] RST_BLUE  = 32'h0000_00FF;
    localparam logic [WORD_BITS-1:0] RST_ALPHA = 32'hFF00_0000;

    // One channel's mask together with its lowest set bit and its set-bit count.
    typedef struct packed {
        logic [WORD_BITS-1:0] mask;
        logic [POS_BITS-1:0]  pos;
        logic [WID_BITS-1:0]  width;
    } chan_cfg_t;

    typedef chan_cfg_t [NUM_CHAN-1:0]          fmt_cfg_t;
    typedef logic [NUM_CHAN-1:0][WORD_BITS-1:0] chan_words_t;

    // Position of the lowest set bit; zero for an empty mask.
    function automatic logic [POS_BITS-1:0] mask_pos(input logic [WORD_BITS-1:0] m);
        logic [POS_BITS-1:0] p;
        p = '0;
        for (int i = WORD_BITS - 1; i >= 0; i--) begin
            if (m[i]) begin
                p = POS_BITS'(i);
            end
        end
        return p;
    endfunction

    // Number of set bits in the mask.
    function automatic logic [WID_BITS-1:0] mask_width(input logic [WORD_BITS-1:0] m);
        logic [WID_BITS-1:0] n;
        n = '0;
        for (int i = 0; i < WORD_BITS; i++) begin
            n = n + WID_BITS'(m[i]);
        end
        return n;
    endfunction

    // Full channel configuration for a mask.
    function automatic chan_cfg_t make_cfg(input logic [WORD_BITS-1:0] m);
        chan_cfg_t c;
        c.mask  = m;
        c.pos   = mask_pos(m);
        c.width = mask_width(m);
        return c;
    endfunction

endpackage

`default_nettype wire

// ----- hdl/pmfc_cfg.sv -----
// Configuration register file for the pixel mask format converter.
// Stores the eight channel masks with their derived positions and widths; uses pmfc_pkg.
`default_nettype none

module pmfc_cfg (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [pmfc_pkg::IDX_BITS-1:0]   cfg_index,
    input  wire logic [pmfc_pkg::WORD_BITS-1:0]  cfg_data,
    output pmfc_pkg::fmt_cfg_t                   src_cfg,
    output pmfc_pkg::fmt_cfg_t                   dst_cfg
);

    pmfc_pkg::fmt_cfg_t  src_cfg_reg;
    pmfc_pkg::fmt_cfg_t  dst_cfg_reg;
    pmfc_pkg::chan_cfg_t wr_cfg;
    logic                wr_en;

    // Position and width are worked out once, when the mask is written.
    assign cfg_ready = 1'b1;
    assign wr_en     = cfg_valid && cfg_ready;
    assign wr_cfg    = pmfc_pkg::make_cfg(cfg_data);

    // Register file; writes to indexes beyond the list are dropped.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            src_cfg_reg[pmfc_pkg::CHAN_RED]   <= pmfc_pkg::make_cfg(pmfc_pkg::RST_RED);
            src_cfg_reg[pmfc_pkg::CHAN_GREEN] <= pmfc_pkg::make_cfg(pmfc_pkg::RST_GREEN);
            src_cfg_reg[pmfc_pkg::CHAN_BLUE]  <= pmfc_pkg::make_cfg(pmfc_pkg::RST_BLUE);
            src_cfg_reg[pmfc_pkg::CHAN_ALPHA] <= pmfc_pkg::make_cfg(pmfc_pkg::RST_ALPHA);
            dst_cfg_reg[pmfc_pkg::CHAN_RED]   <= pmfc_pkg::make_cfg(pmfc_pkg::RST_RED);
            dst_cfg_reg[pmfc_pkg::CHAN_GREEN] <= pmfc_pkg::make_cfg(pmfc_pkg::RST_GREEN);
            dst_cfg_reg[pmfc_pkg::CHAN_BLUE]  <= pmfc_pkg::make_cfg(pmfc_pkg::RST_BLUE);
            dst_cfg_reg[pmfc_pkg::CHAN_ALPHA] <= pmfc_pkg::make_cfg(pmfc_pkg::RST_ALPHA);
        end else if (wr_en) begin
            case (cfg_index)
                pmfc_pkg::REG_SRC_RED:   src_cfg_reg[pmfc_pkg::CHAN_RED]   <= wr_cfg;
                pmfc_pkg::REG_SRC_GREEN: src_cfg_reg[pmfc_pkg::CHAN_GREEN] <= wr_cfg;
                pmfc_pkg::REG_SRC_BLUE:  src_cfg_reg[pmfc_pkg::CHAN_BLUE]  <= wr_cfg;
                pmfc_pkg::REG_SRC_ALPHA: src_cfg_reg[pmfc_pkg::CHAN_ALPHA] <= wr_cfg;
                pmfc_pkg::REG_DST_RED:   dst_cfg_reg[pmfc_pkg::CHAN_RED]   <= wr_cfg;
                pmfc_pkg::REG_DST_GREEN: dst_cfg_reg[pmfc_pkg::CHAN_GREEN] <= wr_cfg;
                pmfc_pkg::REG_DST_BLUE:  dst_cfg_reg[pmfc_pkg::CHAN_BLUE]  <= wr_cfg;
                pmfc_pkg::REG_DST_ALPHA: dst_cfg_reg[pmfc_pkg::CHAN_ALPHA] <= wr_cfg;
                default: begin
                end
            endcase
        end
    end

    assign src_cfg = src_cfg_reg;
    assign dst_cfg = dst_cfg_reg;

endmodule

`default_nettype wire

// ----- hdl/pmfc_decode.sv -----
// Source side of the converter: two pipeline stages that extract each source
// channel and left-align it to a full word. Uses pmfc_pkg.
`default_nettype none

module pmfc_decode (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire pmfc_pkg::fmt_cfg_t              src_cfg,
    input  wire logic                            in_valid,
    output logic                                 in_ready,
    input  wire logic [pmfc_pkg::WORD_BITS-1:0]  in_word,
    output logic                                 out_valid,
    input  wire logic                            out_ready,
    output pmfc_pkg::chan_words_t                out_aligned
);

    logic                  ext_valid_reg;
    logic                  aln_valid_reg;
    logic                  ext_ready;
    logic                  aln_ready;
    pmfc_pkg::chan_words_t ext_reg;
    pmfc_pkg::chan_words_t ext_next;
    pmfc_pkg::chan_words_t aln_reg;
    pmfc_pkg::chan_words_t aln_next;

    // A stage takes new data when it is empty or its content moves on.
    assign aln_ready = !aln_valid_reg || out_ready;
    assign ext_ready = !ext_valid_reg || aln_ready;
    assign in_ready  = ext_ready;

    // Stage one: shift each channel down to bit zero and keep its width.
    always_comb begin
        logic [pmfc_pkg::WORD_BITS-1:0] pix;
        pix = in_word & pmfc_pkg::PIX_MASK;
        for (int c = 0; c < pmfc_pkg::NUM_CHAN; c++) begin
            ext_next[c] = (pix >> src_cfg[c].pos) &
                          ~(pmfc_pkg::ALL_ONES << src_cfg[c].width);
        end
    end

    // Stage two: left-align, replicating a set low bit into the vacated bits.
    always_comb begin
        logic [pmfc_pkg::WID_BITS-1:0] sh;
        for (int c = 0; c < pmfc_pkg::NUM_CHAN; c++) begin
            sh = pmfc_pkg::WID_BITS'(pmfc_pkg::WORD_BITS) - src_cfg[c].width;
            if (src_cfg[c].width == '0) begin
                // A missing alpha is opaque; a missing color is zero.
                aln_next[c] = (c == int'(pmfc_pkg::CHAN_ALPHA)) ? pmfc_pkg::ALL_ONES : '0;
            end else if (ext_reg[c][0]) begin
                aln_next[c] = (ext_reg[c] << sh) | ~(pmfc_pkg::ALL_ONES << sh);
            end else begin
                aln_next[c] = ext_reg[c] << sh;
            end
        end
    end

    // Valid bits of both stages.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ext_valid_reg <= 1'b0;
            aln_valid_reg <= 1'b0;
        end else begin
            if (ext_ready) begin
                ext_valid_reg <= in_valid;
            end
            if (aln_ready) begin
                aln_valid_reg <= ext_valid_reg;
            end
        end
    end

    // Data registers load only with a valid transaction behind them.
    always_ff @(posedge aclk) begin
        if (ext_ready && in_valid) begin
            ext_reg <= ext_next;
        end
        if (aln_ready && ext_valid_reg) begin
            aln_reg <= aln_next;
        end
    end

    assign out_valid   = aln_valid_reg;
    assign out_aligned = aln_reg;

endmodule

`default_nettype wire

// ----- hdl/pmfc_encode.sv -----
// Destination side of the converter: two pipeline stages that take the top
// bits of each aligned channel and pack them at the destination masks. Uses pmfc_pkg.
`default_nettype none

module pmfc_encode (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire pmfc_pkg::fmt_cfg_t              dst_cfg,
    input  wire logic                            in_valid,
    output logic                                 in_ready,
    input  wire pmfc_pkg::chan_words_t           in_aligned,
    output logic                                 out_valid,
    input  wire logic                            out_ready,
    output logic [pmfc_pkg::WORD_BITS-1:0]       out_word
);

    logic                           top_valid_reg;
    logic                           pack_valid_reg;
    logic                           top_ready;
    logic                           pack_ready;
    pmfc_pkg::chan_words_t          top_reg;
    pmfc_pkg::chan_words_t          top_next;
    logic [pmfc_pkg::WORD_BITS-1:0] pack_reg;
    logic [pmfc_pkg::WORD_BITS-1:0] pack_next;

    // The packing register is the output register of the block.
    assign pack_ready = !pack_valid_reg || out_ready;
    assign top_ready  = !top_valid_reg || pack_ready;
    assign in_ready   = top_ready;

    // Stage three: keep the top bits of each channel, right-justified.
    always_comb begin
        logic [pmfc_pkg::WID_BITS-1:0] sh;
        for (int c = 0; c < pmfc_pkg::NUM_CHAN; c++) begin
            sh          = pmfc_pkg::WID_BITS'(pmfc_pkg::WORD_BITS) - dst_cfg[c].width;
            top_next[c] = in_aligned[c] >> sh;
        end
    end

    // Stage four: place each channel, clip to its mask and merge.
    always_comb begin
        pack_next = '0;
        for (int c = 0; c < pmfc_pkg::NUM_CHAN; c++) begin
            pack_next = pack_next | ((top_reg[c] << dst_cfg[c].pos) & dst_cfg[c].mask);
        end
        pack_next = pack_next & pmfc_pkg::PIX_MASK;
    end

    // Valid bits of both stages.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            top_valid_reg  <= 1'b0;
            pack_valid_reg <= 1'b0;
        end else begin
            if (top_ready) begin
                top_valid_reg <= in_valid;
            end
            if (pack_ready) begin
                pack_valid_reg <= top_valid_reg;
            end
        end
    end

    // Data registers.
    always_ff @(posedge aclk) begin
        if (top_ready && in_valid) begin
            top_reg <= top_next;
        end
        if (pack_ready && top_valid_reg) begin
            pack_reg <= pack_next;
        end
    end

    assign out_valid = pack_valid_reg;
    assign out_word  = pack_reg;

endmodule

`default_nettype wire

// ----- hdl/pixel_mask_format_converter.sv -----
// Pixel mask format converter: converts one packed pixel per clock between two
// RGBA layouts described by eight channel masks (source red, green, blue, alpha
// at indexes 0 to 3, destination at 4 to 7; reset is 8-bit ARGB on both sides).
// Each pixel passes four register stages (extract, align, select, pack), and a
// new pixel is taken every cycle while the output is drained; a stall on the
// result side fills the four stages before s_ready drops. Masks are written
// through the cfg port, which is always ready, and should only change while
// no pixel is in flight. A channel with a zero mask is absent: missing source
// alpha reads as opaque, other missing channels read as zero.
// Depends on pmfc_pkg, pmfc_cfg, pmfc_decode and pmfc_encode.
`default_nettype none

module pixel_mask_format_converter (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [pmfc_pkg::IDX_BITS-1:0]   cfg_index,
    input  wire logic [pmfc_pkg::WORD_BITS-1:0]  cfg_data,
    input  wire logic                            s_valid,
    output logic                                 s_ready,
    input  wire logic [pmfc_pkg::WORD_BITS-1:0]  s_source_pixel,
    output logic                                 m_valid,
    input  wire logic                            m_ready,
    output logic [pmfc_pkg::WORD_BITS-1:0]       m_converted_pixel
);

    pmfc_pkg::fmt_cfg_t    src_cfg;
    pmfc_pkg::fmt_cfg_t    dst_cfg;
    pmfc_pkg::chan_words_t aligned;
    logic                  mid_valid;
    logic                  mid_ready;
    logic [2:0]            occ_reg;
    logic [2:0]            occ_next;

    // Mask registers.
    pmfc_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .src_cfg   (src_cfg),
        .dst_cfg   (dst_cfg)
    );

    // Source channel extraction and alignment.
    pmfc_decode u_decode (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .src_cfg     (src_cfg),
        .in_valid    (s_valid),
        .in_ready    (s_ready),
        .in_word     (s_source_pixel),
        .out_valid   (mid_valid),
        .out_ready   (mid_ready),
        .out_aligned (aligned)
    );

    // Destination channel packing.
    pmfc_encode u_encode (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .dst_cfg    (dst_cfg),
        .in_valid   (mid_valid),
        .in_ready   (mid_ready),
        .in_aligned (aligned),
        .out_valid  (m_valid),
        .out_ready  (m_ready),
        .out_word   (m_converted_pixel)
    );

    // Count of pixel transactions inside the pipeline.
    always_comb begin
        occ_next = occ_reg;
        if ((s_valid && s_ready) && !(m_valid && m_ready)) begin
            occ_next = occ_reg + 3'd1;
        end else if (!(s_valid && s_ready) && (m_valid && m_ready)) begin
            occ_next = occ_reg - 3'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            occ_reg <= '0;
        end else begin
            occ_reg <= occ_next;
        end
    end

    // The four stages never hold more than four pixels.
    a_occ_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        occ_reg <= 3'd4)
        else $error("pipeline holds more than four pixels");

    // No result is offered while the pipeline is empty.
    a_empty_no_out: assert property (@(posedge aclk) disable iff (!aresetn)
        (occ_reg == 3'd0) |-> !m_valid)
        else $error("result offered with an empty pipeline");

    // Input back-pressure only comes from a stalled, full output.
    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (m_valid && !m_ready && occ_reg == 3'd4))
        else $error("input stalled without a full, stalled pipeline");

    // Reset empties the pipeline.
    a_reset_empty: assert property (@(posedge aclk)
        $past(!aresetn) |-> (!m_valid && occ_reg == 3'd0))
        else $error("pipeline not empty after reset");

endmodule

`default_nettype wire

// ----- tb/tb_top.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for pixel_mask_format_converter.
// Drives pixels and mask writes, predicts every converted pixel and checks it in order.
// Depends on pmfc_pkg and the converter RTL only.

module tb_top;

    localparam int CLK_HALF      = 4;
    localparam int LATENCY       = 4;
    localparam int SETTLE        = 8;
    localparam int STALL_LIMIT   = 2000;
    localparam int MAX_WAIT      = 17;
    localparam int RANDOM_PHASES = 15;
    localparam int PHASE_PIXELS  = 50;
    localparam int LAST_INDEX    = (1 << pmfc_pkg::IDX_BITS) - 1;
    localparam int REG_BITS      = $clog2(pmfc_pkg::NUM_REGS);

    typedef struct {
        logic [pmfc_pkg::WORD_BITS-1:0] source;
        logic [pmfc_pkg::WORD_BITS-1:0] converted;
    } pixel_due_t;

    logic                           aclk = 1'b0;
    logic                           aresetn = 1'b0;
    logic                           cfg_valid = 1'b0;
    logic                           cfg_ready;
    logic [pmfc_pkg::IDX_BITS-1:0]  cfg_index = '0;
    logic [pmfc_pkg::WORD_BITS-1:0] cfg_data = '0;
    logic                           s_valid = 1'b0;
    logic                           s_ready;
    logic [pmfc_pkg::WORD_BITS-1:0] s_source_pixel = '0;
    logic                           m_valid;
    logic                           m_ready = 1'b0;
    logic [pmfc_pkg::WORD_BITS-1:0] m_converted_pixel;

    // Shadow copy of the eight mask registers, indexed by register index.
    logic [pmfc_pkg::WORD_BITS-1:0] fmt_mask [pmfc_pkg::NUM_REGS];

    logic [pmfc_pkg::WORD_BITS-1:0] pixel_queue [$];
    pixel_due_t                     converted_due [$];

    int unsigned error_count = 0;
    int unsigned pixels_sent = 0;
    int unsigned pixels_checked = 0;
    int unsigned mask_writes = 0;
    int unsigned settings_used = 0;
    int unsigned send_wait = 0;
    int unsigned take_wait = 0;
    int unsigned idle_cycles = 0;
    bit          send_steady = 1'b0;
    bit          take_steady = 1'b0;
    bit          pixel_taken = 1'b0;
    bit          result_taken = 1'b0;

    pixel_mask_format_converter u_top (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_source_pixel    (s_source_pixel),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_converted_pixel (m_converted_pixel)
    );

    // Free-running clock.
    initial begin
        forever #(CLK_HALF) aclk = ~aclk;
    end

    // Index of the lowest set bit of a nonzero mask.
    function automatic int unsigned low_bit(input logic [pmfc_pkg::WORD_BITS-1:0] m);
        int unsigned p;
        p = 0;
        while (p < pmfc_pkg::WORD_BITS && !m[p]) begin
            p++;
        end
        return p;
    endfunction

    // Shadow mask of one register.
    function automatic logic [pmfc_pkg::WORD_BITS-1:0] mask_of(input pmfc_pkg::reg_idx_t r);
        return fmt_mask[REG_BITS'(r)];
    endfunction

    // Extract a source channel and stretch it to a full 32-bit value.
    function automatic logic [pmfc_pkg::WORD_BITS-1:0] widen_channel(
            input logic [pmfc_pkg::WORD_BITS-1:0] pix,
            input logic [pmfc_pkg::WORD_BITS-1:0] m,
            input logic [pmfc_pkg::WORD_BITS-1:0] absent);
        int unsigned w;
        int unsigned p;
        logic [63:0] field;
        logic [63:0] aligned;
        w = $countones(m);
        if (w == 0) begin
            return absent;
        end
        p = low_bit(m);
        field = ({32'd0, pix} >> p) & ((64'd1 << w) - 64'd1);
        aligned = (field << (32 - w)) & {32'd0, {pmfc_pkg::WORD_BITS{1'b1}}};
        // An odd channel value fills the vacated low bits with ones.
        if (field[0]) begin
            aligned = aligned | ((64'd1 << (32 - w)) - 64'd1);
        end
        return aligned[pmfc_pkg::WORD_BITS-1:0];
    endfunction

    // Take the top bits of a widened value and place them under a destination mask.
    function automatic logic [pmfc_pkg::WORD_BITS-1:0] narrow_channel(
            input logic [pmfc_pkg::WORD_BITS-1:0] wide,
            input logic [pmfc_pkg::WORD_BITS-1:0] m);
        int unsigned w;
        int unsigned p;
        logic [63:0] placed;
        w = $countones(m);
        if (w == 0) begin
            return '0;
        end
        p = low_bit(m);
        placed = ({32'd0, wide} >> (32 - w)) << p;
        return placed[pmfc_pkg::WORD_BITS-1:0] & m;
    endfunction

    // Expected destination pixel for one source pixel under the current masks.
    function automatic logic [pmfc_pkg::WORD_BITS-1:0] convert_pixel(
            input logic [pmfc_pkg::WORD_BITS-1:0] raw);
        logic [pmfc_pkg::WORD_BITS-1:0] pix;
        logic [pmfc_pkg::WORD_BITS-1:0] red;
        logic [pmfc_pkg::WORD_BITS-1:0] green;
        logic [pmfc_pkg::WORD_BITS-1:0] blue;
        logic [pmfc_pkg::WORD_BITS-1:0] alpha;
        pix   = raw & pmfc_pkg::PIX_MASK;
        red   = widen_channel(pix, mask_of(pmfc_pkg::REG_SRC_RED), '0);
        green = widen_channel(pix, mask_of(pmfc_pkg::REG_SRC_GREEN), '0);
        blue  = widen_channel(pix, mask_of(pmfc_pkg::REG_SRC_BLUE), '0);
        alpha = widen_channel(pix, mask_of(pmfc_pkg::REG_SRC_ALPHA), '1);
        return (narrow_channel(red, mask_of(pmfc_pkg::REG_DST_RED)) |
                narrow_channel(green, mask_of(pmfc_pkg::REG_DST_GREEN)) |
                narrow_channel(blue, mask_of(pmfc_pkg::REG_DST_BLUE)) |
                narrow_channel(alpha, mask_of(pmfc_pkg::REG_DST_ALPHA))) &
               pmfc_pkg::PIX_MASK;
    endfunction

    function automatic int unsigned draw_wait(input bit steady);
        return steady ? 0 : $urandom_range(0, MAX_WAIT);
    endfunction

    // Random mask: absent, full width, scattered bits, a byte lane or a contiguous run.
    function automatic logic [pmfc_pkg::WORD_BITS-1:0] draw_mask();
        int unsigned kind;
        int unsigned w;
        logic [63:0] run;
        kind = $urandom_range(0, 19);
        if (kind < 2) begin
            return '0;
        end else if (kind == 2) begin
            return '1;
        end else if (kind < 6) begin
            return $urandom();
        end else if (kind < 8) begin
            return 32'h0000_00FF << (8 * $urandom_range(0, 3));
        end
        w = $urandom_range(1, pmfc_pkg::WORD_BITS);
        run = ((64'd1 << w) - 64'd1) << $urandom_range(0, pmfc_pkg::WORD_BITS - w);
        return run[pmfc_pkg::WORD_BITS-1:0];
    endfunction

    function automatic logic [pmfc_pkg::WORD_BITS-1:0] draw_pixel();
        int unsigned kind;
        kind = $urandom_range(0, 9);
        if (kind == 0) begin
            return '0;
        end else if (kind == 1) begin
            return '1;
        end
        return $urandom();
    endfunction

    task automatic report_mismatch(input string msg);
        $display("tb_top: ERROR at %0t: %s", $realtime, msg);
        error_count++;
    endtask

    // One configuration transaction; the shadow copy follows the accepted write.
    task automatic write_reg(input logic [pmfc_pkg::IDX_BITS-1:0] idx,
                             input logic [pmfc_pkg::WORD_BITS-1:0] data);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge aclk);
        while (!cfg_ready) begin
            @(posedge aclk);
        end
        if (idx < pmfc_pkg::NUM_REGS) begin
            fmt_mask[idx[REG_BITS-1:0]] = data;
        end
        mask_writes++;
    endtask

    // Drop the write channel and give the new masks time to settle.
    task automatic finish_config();
        @(negedge aclk);
        cfg_valid <= 1'b0;
        repeat (LATENCY) @(negedge aclk);
        settings_used++;
    endtask

    task automatic load_format(input logic [pmfc_pkg::WORD_BITS-1:0] src_r,
                               input logic [pmfc_pkg::WORD_BITS-1:0] src_g,
                               input logic [pmfc_pkg::WORD_BITS-1:0] src_b,
                               input logic [pmfc_pkg::WORD_BITS-1:0] src_a,
                               input logic [pmfc_pkg::WORD_BITS-1:0] dst_r,
                               input logic [pmfc_pkg::WORD_BITS-1:0] dst_g,
                               input logic [pmfc_pkg::WORD_BITS-1:0] dst_b,
                               input logic [pmfc_pkg::WORD_BITS-1:0] dst_a);
        write_reg(pmfc_pkg::REG_SRC_RED, src_r);
        write_reg(pmfc_pkg::REG_SRC_GREEN, src_g);
        write_reg(pmfc_pkg::REG_SRC_BLUE, src_b);
        write_reg(pmfc_pkg::REG_SRC_ALPHA, src_a);
        write_reg(pmfc_pkg::REG_DST_RED, dst_r);
        write_reg(pmfc_pkg::REG_DST_GREEN, dst_g);
        write_reg(pmfc_pkg::REG_DST_BLUE, dst_b);
        write_reg(pmfc_pkg::REG_DST_ALPHA, dst_a);
        finish_config();
    endtask

    // Hold off until every queued pixel has gone in and every result has come back.
    task automatic wait_idle();
        @(posedge aclk);
        while (pixel_queue.size() != 0 || s_valid || converted_due.size() != 0) begin
            @(posedge aclk);
        end
        repeat (LATENCY) @(posedge aclk);
    endtask

    // Record each accepted pixel transaction together with its predicted result.
    always @(posedge aclk) begin : pixel_capture
        if (aresetn && s_valid && s_ready) begin
            converted_due.push_back('{source: s_source_pixel,
                                      converted: convert_pixel(s_source_pixel)});
            pixel_taken = 1'b1;
            pixels_sent++;
        end
    end

    // Pixel driver: presents queued pixels with a random gap drawn after each one.
    always @(negedge aclk) begin : pixel_driver
        logic holding;
        holding = s_valid && !pixel_taken;
        pixel_taken = 1'b0;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!holding) begin
            if (send_wait > 0) begin
                send_wait--;
                s_valid <= 1'b0;
            end else if (pixel_queue.size() > 0) begin
                s_source_pixel <= pixel_queue.pop_front();
                s_valid <= 1'b1;
                send_wait = draw_wait(send_steady);
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Result monitor: compares each accepted result with the oldest prediction.
    always @(posedge aclk) begin : result_monitor
        pixel_due_t due;
        if (aresetn && m_valid && m_ready) begin
            result_taken = 1'b1;
            if (converted_due.size() == 0) begin
                report_mismatch($sformatf("unexpected result %h", m_converted_pixel));
            end else begin
                due = converted_due.pop_front();
                pixels_checked++;
                if (m_converted_pixel !== due.converted) begin
                    report_mismatch($sformatf("converted_pixel for source %h: expected %h, got %h",
                                              due.source, due.converted, m_converted_pixel));
                end
            end
        end
    end

    // Result ready driver: stalls a random number of cycles after each result.
    always @(negedge aclk) begin : result_ready_driver
        if (result_taken) begin
            result_taken = 1'b0;
            take_wait = draw_wait(take_steady);
        end
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (take_wait > 0) begin
            take_wait--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // Watchdog: ends the run when no transaction of any kind completes for too long.
    always @(posedge aclk) begin : watchdog
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) ||
            (cfg_valid && cfg_ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("tb_top: no progress for %0d cycles, %0d results outstanding",
                         idle_cycles, converted_due.size());
                $display("tb_top: done, errors");
                $finish;
            end
        end
    end

    // Stimulus sequence.
    initial begin
        fmt_mask = '{pmfc_pkg::RST_RED, pmfc_pkg::RST_GREEN,
                     pmfc_pkg::RST_BLUE, pmfc_pkg::RST_ALPHA,
                     pmfc_pkg::RST_RED, pmfc_pkg::RST_GREEN,
                     pmfc_pkg::RST_BLUE, pmfc_pkg::RST_ALPHA};

        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Reset formats: extremes and odd channel values that fill low bits.
        pixel_queue = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h0101_0101, 32'hFEFE_FEFE};
        wait_idle();

        // 16-bit RGB without alpha into 32-bit ARGB; alpha must come out opaque.
        load_format(32'h0000_F800, 32'h0000_07E0, 32'h0000_001F, 32'h0000_0000,
                    pmfc_pkg::RST_RED, pmfc_pkg::RST_GREEN, pmfc_pkg::RST_BLUE,
                    pmfc_pkg::RST_ALPHA);
        pixel_queue = '{32'h0000_FFFF, 32'h0000_0000, 32'h0000_F801, 32'h0000_07E0,
                        32'hFFFF_0821};
        wait_idle();

        // Full-width red passes straight through.
        load_format('1, '0, '0, '0, '1, '0, '0, '0);
        pixel_queue = '{32'h8000_0001, 32'h7FFF_FFFE};
        wait_idle();

        // Absent source alpha into a full-width destination alpha.
        load_format('0, '0, '0, '0, '0, '0, '0, '1);
        pixel_queue = '{32'h1234_5678};
        wait_idle();

        // Scattered masks on both sides.
        load_format(32'h00F0_000F, 32'h0000_FF00, 32'h0000_0000, 32'h8000_0001,
                    32'hA5A5_A5A5, 32'h0000_0F0F, 32'h0000_0000, 32'h0C00_0003);
        pixel_queue = '{32'hC3A5_005A, 32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_000F};
        wait_idle();

        // No destination channels at all.
        load_format(pmfc_pkg::RST_RED, pmfc_pkg::RST_GREEN, pmfc_pkg::RST_BLUE,
                    pmfc_pkg::RST_ALPHA, '0, '0, '0, '0);
        pixel_queue = '{32'hFFFF_FFFF};
        wait_idle();

        // Writes past the last register must leave the masks alone.
        write_reg(pmfc_pkg::REG_SRC_RED, pmfc_pkg::RST_RED);
        write_reg(pmfc_pkg::REG_DST_RED, pmfc_pkg::RST_RED);
        write_reg(pmfc_pkg::REG_DST_GREEN, pmfc_pkg::RST_GREEN);
        write_reg(pmfc_pkg::REG_DST_BLUE, pmfc_pkg::RST_BLUE);
        write_reg(pmfc_pkg::REG_DST_ALPHA, pmfc_pkg::RST_ALPHA);
        write_reg(pmfc_pkg::IDX_BITS'(pmfc_pkg::NUM_REGS), '1);
        write_reg(pmfc_pkg::IDX_BITS'(LAST_INDEX), '0);
        finish_config();
        pixel_queue = '{32'h1122_3344};
        wait_idle();

        // Random phases: new masks while idle, then a burst of random pixels.
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            send_steady = ($urandom_range(0, 3) == 0);
            take_steady = ($urandom_range(0, 3) == 0);
            for (int r = pmfc_pkg::REG_SRC_RED; r <= pmfc_pkg::REG_DST_ALPHA; r++) begin
                if (phase == 1) begin
                    write_reg(pmfc_pkg::IDX_BITS'(r), '1);
                end else if (phase == 2) begin
                    write_reg(pmfc_pkg::IDX_BITS'(r), '0);
                end else if (phase == 0 || $urandom_range(0, 3) != 0) begin
                    write_reg(pmfc_pkg::IDX_BITS'(r), draw_mask());
                end
            end
            if ($urandom_range(0, 3) == 0) begin
                write_reg(pmfc_pkg::IDX_BITS'($urandom_range(pmfc_pkg::NUM_REGS, LAST_INDEX)),
                          $urandom());
            end
            finish_config();
            for (int n = 0; n < PHASE_PIXELS; n++) begin
                pixel_queue.push_back(draw_pixel());
            end
            wait_idle();
        end

        repeat (SETTLE) @(posedge aclk);
        $display("tb_top: %0d pixels checked over %0d mask settings (%0d mask writes),",
                 pixels_checked, settings_used, mask_writes);
        $display("tb_top: covering absent, full-width, scattered and out-of-range register cases");
        if (error_count == 0) begin
            $display("tb_top: done, clean");
        end else begin
            $display("tb_top: done, errors");
        end
        $finish;
    end

endmodule
